>>> rtl/core/mavg_pkg.sv
package mavg_pkg;

   localparam int SampleBitsDefault = 12;
   localparam int MaxWindowDefault  = 64;

   // window_length register
   localparam int CfgBits     = 7;
   localparam int CfgResetLen = 64;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

>>> rtl/core/mavg_req_if.sv
interface mavg_req_if #(
   parameter int DATA_W = mavg_pkg::SampleBitsDefault
);
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

>>> rtl/core/mavg_rsp_if.sv
interface mavg_rsp_if #(
   parameter int DATA_W = mavg_pkg::SampleBitsDefault
);
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] average;
   logic [DATA_W-1:0] latest;
   logic              window_full;

   modport source (output valid, output average, output latest, output window_full,
                   input ready);
   modport sink   (input valid, input average, input latest, input window_full,
                   output ready);
endinterface

>>> rtl/core/mavg_ram.sv
module mavg_ram #(
   parameter int WIDTH = mavg_pkg::SampleBitsDefault,
   parameter int DEPTH = mavg_pkg::MaxWindowDefault
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/mavg_div.sv
// Restoring divider, one quotient bit per cycle, MSB first.
module mavg_div #(
   parameter int SUM_W = 18,
   parameter int LEN_W = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [SUM_W-1:0]         dividend,
   input  logic [LEN_W-1:0]         divisor,
   output logic [SUM_W-1:0]         quotient,
   output mavg_pkg::div_status_type status
);

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [LEN_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [LEN_W:0]   trial;
   logic [LEN_W:0]   diff;
   logic             ge;

   always_comb begin
      trial  = {rem_ff, quo_ff[SUM_W-1]};
      ge     = (trial >= {1'b0, dsr_ff});
      diff   = trial - {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(SUM_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[SUM_W-2:0], ge};
         rem_in = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

>>> rtl/core/adc_moving_average_top.sv
// Channel   Dir  Payload                                   Handshake
// req_chan  in   sample                                    valid/ready
// rsp_chan  out  average, latest, window_full              valid/ready
// csr       in   window_length (csr_wdata)                 csr_wen, no read-back
//
// One request passes through an accept step with the ring read, a sum update,
// then the bit-serial divider, one quotient bit per cycle over the SUM_W-bit
// running sum. Reset is synchronous; it clears the sum, count and position,
// and sets the window to CfgResetLen, capped at MAX_WINDOW. The ring is not
// cleared: the value read from a slot is only used once that slot was written.
// A finished result waits in the output register; a new request is taken
// meanwhile, and the divider holds its result until the output register frees.
module adc_moving_average_top #(
   parameter int MAX_WINDOW  = mavg_pkg::MaxWindowDefault,
   parameter int SAMPLE_BITS = mavg_pkg::SampleBitsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [mavg_pkg::CfgBits-1:0]  csr_wdata,
   mavg_req_if.sink                      req_chan,
   mavg_rsp_if.source                    rsp_chan
);

   localparam int LEN_W   = $clog2(MAX_WINDOW + 1);
   localparam int POS_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int CMP_W   = (LEN_W > mavg_pkg::CfgBits) ? LEN_W : mavg_pkg::CfgBits;
   localparam int RST_LEN = (mavg_pkg::CfgResetLen < MAX_WINDOW) ?
                            mavg_pkg::CfgResetLen : MAX_WINDOW;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE
   } state_type;

   state_type              state_ff, state_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [LEN_W-1:0]       count_ff, count_in;
   logic                   full_ff, full_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] average_ff, average_in;
   logic [SAMPLE_BITS-1:0] latest_ff, latest_in;
   logic                   wfull_ff, wfull_in;

   logic                   accept;
   logic [CMP_W-1:0]       wl_ext;
   logic [CMP_W-1:0]       wl_eff;
   logic [LEN_W-1:0]       pos_next;
   logic [LEN_W-1:0]       count_next;
   logic [SUM_W-1:0]       drop;
   logic                   ram_wr_en;
   logic [SAMPLE_BITS-1:0] ram_rd_data;
   logic                   div_start;
   logic [SUM_W-1:0]       quotient;
   mavg_pkg::div_status_type div_status;

   assign accept         = req_chan.valid && (state_ff == ST_IDLE);
   assign req_chan.ready = (state_ff == ST_IDLE);

   // window length: zero acts as one, anything above the ring size saturates
   always_comb begin
      wl_ext = CMP_W'(csr_wdata);
      if (wl_ext == '0) begin
         wl_eff = CMP_W'(1);
      end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
         wl_eff = CMP_W'(MAX_WINDOW);
      end else begin
         wl_eff = wl_ext;
      end
   end

   always_comb begin
      pos_next   = LEN_W'(pos_ff) + LEN_W'(1);
      count_next = count_ff + LEN_W'(1);
      drop       = full_ff ? SUM_W'(ram_rd_data) : '0;

      state_in     = state_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      full_in      = full_ff;
      sum_in       = sum_ff;
      sample_in    = sample_ff;
      average_in   = average_ff;
      latest_in    = latest_ff;
      wfull_in     = wfull_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      ram_wr_en    = 1'b0;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sample_in = req_chan.sample;
               state_in  = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // ring slot read last cycle is the oldest sample once full
            sum_in    = sum_ff - drop + SUM_W'(sample_ff);
            ram_wr_en = 1'b1;
            pos_in    = (pos_next == len_ff) ? '0 : pos_next[POS_W-1:0];
            if (!full_ff) begin
               count_in = count_next;
               full_in  = (count_next == len_ff);
            end
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_status.done && (!rsp_valid_ff || rsp_chan.ready)) begin
               rsp_valid_in = 1'b1;
               average_in   = full_ff ? quotient[SAMPLE_BITS-1:0] : '0;
               latest_in    = sample_ff;
               wfull_in     = full_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wen) begin
         len_in   = wl_eff[LEN_W-1:0];
         pos_in   = '0;
         count_in = '0;
         full_in  = 1'b0;
         sum_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= LEN_W'(RST_LEN);
         pos_ff       <= '0;
         count_ff     <= '0;
         full_ff      <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         full_ff      <= full_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff  <= sample_in;
      average_ff <= average_in;
      latest_ff  <= latest_in;
      wfull_ff   <= wfull_in;
   end

   mavg_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pos_ff),
      .wr_data (sample_ff),
      .rd_en   (accept),
      .rd_addr (pos_ff),
      .rd_data (ram_rd_data)
   );

   mavg_div #(
      .SUM_W (SUM_W),
      .LEN_W (LEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (len_ff),
      .quotient (quotient),
      .status   (div_status)
   );

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.average     = average_ff;
   assign rsp_chan.latest      = latest_ff;
   assign rsp_chan.window_full = wfull_ff;

   a_pos_in_window: assert property (@(posedge clock) disable iff (reset)
      LEN_W'(pos_ff) < len_ff)
      else $error("ring position outside window");

   a_count_below_len: assert property (@(posedge clock) disable iff (reset)
      !full_ff |-> count_ff < len_ff)
      else $error("sample count reached window without full flag");

   a_rsp_after_div: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(div_status.done))
      else $error("response raised without a finished division");

   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !div_status.busy)
      else $error("divider busy while accepting requests");

   a_avg_zero_unfilled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !wfull_ff |-> average_ff == '0)
      else $error("nonzero average before window filled");

endmodule
